>>> hw/rtl/mr90_pkg.sv
// Shared types and constants for the 90-degree matrix rotator.
// Used by mr90_front, mr90_back and the top level; no dependencies.
`default_nettype none

package mr90_pkg;

  // Width of the side-length register and of side and index values.
  localparam int unsigned SIDE_W  = 4;
  // Width of the element counter in the load path.
  localparam int unsigned COUNT_W = 7;

  // Job handed from the load side to the readout side.
  typedef struct packed {
    logic              bank;
    logic [SIDE_W-1:0] side;
  } cmd_t;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/mr90_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mr90_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mr90_fifo.sv
// Small synchronous FIFO built from registers (any depth of one or more).
// No dependencies.
`default_nettype none

module mr90_fifo #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mr90_front.sv
// Load side: holds the side-length register, writes elements into the
// current bank and issues a readout job per completed matrix. Uses mr90_pkg.
`default_nettype none

module mr90_front #(
  parameter int unsigned MAX_SIDE      = 8,
  parameter int unsigned ELEMENT_WIDTH = 32,
  parameter int unsigned SLOT_W        = 6
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [mr90_pkg::SIDE_W-1:0]        cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [ELEMENT_WIDTH-1:0]    in_element,
  output logic                                    wr_en,
  output logic      [SLOT_W:0]                    wr_addr,
  output logic      [ELEMENT_WIDTH-1:0]           wr_data,
  output logic                                    cmd_valid,
  input  wire logic                               cmd_ready,
  output mr90_pkg::cmd_t                          cmd_data,
  input  wire logic                               bank_release
);

  localparam int unsigned STORE_DEPTH = MAX_SIDE * MAX_SIDE;

  logic [mr90_pkg::SIDE_W-1:0]  matrix_side;
  logic [mr90_pkg::SIDE_W-1:0]  eff_side;
  logic [mr90_pkg::COUNT_W-1:0] load_count;
  logic [mr90_pkg::COUNT_W-1:0] count_inc;
  logic [mr90_pkg::COUNT_W-1:0] total;
  logic [7:0]                   side_sq;
  logic                         wr_bank;
  logic [1:0]                   banks_busy;
  logic                         accept;
  logic                         done;

  always_comb begin
    if (matrix_side == '0) begin
      eff_side = mr90_pkg::SIDE_W'(1);
    end else if (matrix_side > mr90_pkg::SIDE_W'(MAX_SIDE)) begin
      eff_side = mr90_pkg::SIDE_W'(MAX_SIDE);
    end else begin
      eff_side = matrix_side;
    end
  end

  assign side_sq   = 8'(eff_side) * 8'(eff_side);
  assign total     = mr90_pkg::COUNT_W'(side_sq);
  assign count_inc = load_count + 1'b1;
  assign done      = (count_inc >= total);

  // Both banks hold matrices not yet read out: stall loading.
  assign in_ready = (banks_busy != 2'd2) && cmd_ready;
  assign accept   = in_valid && in_ready;

  assign wr_en   = accept && (load_count < mr90_pkg::COUNT_W'(STORE_DEPTH));
  assign wr_addr = {wr_bank, load_count[SLOT_W-1:0]};
  assign wr_data = in_element;

  assign cmd_valid     = accept && done;
  assign cmd_data.bank = wr_bank;
  assign cmd_data.side = eff_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_side <= mr90_pkg::SIDE_W'(MAX_SIDE);
      load_count  <= '0;
      wr_bank     <= 1'b0;
      banks_busy  <= '0;
    end else begin
      if (cfg_we) begin
        matrix_side <= cfg_wdata;
      end
      if (accept) begin
        if (done) begin
          load_count <= '0;
          wr_bank    <= ~wr_bank;
        end else begin
          load_count <= count_inc;
        end
      end
      if (cmd_valid && !bank_release) begin
        banks_busy <= banks_busy + 1'b1;
      end else if (bank_release && !cmd_valid) begin
        banks_busy <= banks_busy - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mr90_back.sv
// Readout side: walks a stored matrix in rotated order, one RAM read per
// cycle into a two-entry output buffer while it has room. Uses mr90_pkg.
`default_nettype none

module mr90_back #(
  parameter int unsigned ELEMENT_WIDTH = 32,
  parameter int unsigned SLOT_W        = 6
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_ready,
  input  mr90_pkg::cmd_t                       cmd_data,
  output logic                                 rd_en,
  output logic      [SLOT_W:0]                 rd_addr,
  input  wire logic [ELEMENT_WIDTH-1:0]        rd_data,
  output logic                                 bank_release,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [ELEMENT_WIDTH-1:0]      out_element,
  output logic                                 out_last
);

  mr90_pkg::back_state_t state;
  mr90_pkg::back_state_t state_next;

  logic                        bank;
  logic [mr90_pkg::SIDE_W-1:0] side;
  logic [mr90_pkg::SIDE_W-1:0] row;
  logic [mr90_pkg::SIDE_W-1:0] col;
  logic [SLOT_W-1:0]           base;
  logic [SLOT_W-1:0]           src;
  logic [SLOT_W-1:0]           base_calc;
  logic [SLOT_W-1:0]           src_row_next;
  logic [SLOT_W-1:0]           src_col_next;
  logic [7:0]                  side_sq;
  logic                        row_end;
  logic                        last_addr;
  logic                        inflight;
  logic                        inflight_last;

  logic [ELEMENT_WIDTH-1:0]    obuf_data [2];
  logic                        obuf_last [2];
  logic                        ohead;
  logic [1:0]                  ocount;
  logic                        otail;
  logic                        opop;
  logic [2:0]                  occ;
  logic                        can_issue;

  assign side_sq   = 8'(cmd_data.side) * 8'(cmd_data.side);
  // Column zero of the rotated row starts at the bottom-left of the input.
  assign base_calc = SLOT_W'(side_sq - 8'(cmd_data.side));

  assign row_end      = (col == side - 1'b1);
  assign last_addr    = row_end && (row == side - 1'b1);
  assign src_row_next = SLOT_W'(8'(base) + 8'(row) + 8'd1);
  assign src_col_next = SLOT_W'(8'(src) - 8'(side));

  // Output buffer: issue a read only when a slot is sure to be free.
  assign out_valid   = (ocount != 2'd0);
  assign out_element = obuf_data[ohead];
  assign out_last    = obuf_last[ohead];
  assign opop        = out_valid && out_ready;
  assign otail       = ohead ^ ocount[0];
  assign occ         = 3'(ocount) + 3'(inflight);
  assign can_issue   = opop ? (occ <= 3'd2) : (occ <= 3'd1);

  assign rd_addr = {bank, src};

  always_comb begin
    state_next = state;
    unique case (state)
      mr90_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          state_next = mr90_pkg::BK_READ;
        end
      end
      mr90_pkg::BK_READ: begin
        if (can_issue && last_addr) begin
          state_next = mr90_pkg::BK_IDLE;
        end
      end
      default: state_next = mr90_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready    = 1'b0;
    rd_en        = 1'b0;
    bank_release = 1'b0;
    unique case (state)
      mr90_pkg::BK_IDLE: begin
        cmd_ready = 1'b1;
      end
      mr90_pkg::BK_READ: begin
        rd_en        = can_issue;
        bank_release = can_issue && last_addr;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mr90_pkg::BK_IDLE;
      inflight <= 1'b0;
      ohead    <= 1'b0;
      ocount   <= '0;
    end else begin
      state    <= state_next;
      inflight <= rd_en;
      if (opop) begin
        ohead <= ~ohead;
      end
      if (inflight && !opop) begin
        ocount <= ocount + 1'b1;
      end else if (opop && !inflight) begin
        ocount <= ocount - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    inflight_last <= last_addr;
    if (inflight) begin
      obuf_data[otail] <= rd_data;
      obuf_last[otail] <= inflight_last;
    end
    if (cmd_valid && cmd_ready) begin
      bank <= cmd_data.bank;
      side <= cmd_data.side;
      row  <= '0;
      col  <= '0;
      base <= base_calc;
      src  <= base_calc;
    end else if (rd_en) begin
      if (row_end) begin
        col <= '0;
        row <= row + 1'b1;
        src <= src_row_next;
      end else begin
        col <= col + 1'b1;
        src <= src_col_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/matrix_rotate_90_cw.sv
// Top level of the 90-degree clockwise square-matrix rotator.
// Instantiates mr90_front, mr90_fifo, mr90_ram and mr90_back; uses mr90_pkg.
//
// channel   signals                          width   direction
// -------   ------------------------------   -----   ---------
// config    cfg_we, cfg_wdata                4       in
// input     in_valid/in_ready, in_element    32      in
// output    out_valid/out_ready, out_element 32+1    out (with out_last)
//
// The store has two banks, so a matrix loads while the previous one is read
// out. The first result of a matrix is offered once its command has passed
// the command queue and job start, and its first element the registered RAM
// read and the output buffer. Readout then issues one RAM read per cycle
// while the two-entry output buffer has room, n*n reads per matrix, returning
// to idle between matrices, paced by the single read port and that buffer.
// Loading stalls only while both banks wait for readout. Reset clears control
// state only; store contents stay undefined until written (no clearing pass).
`default_nettype none

module matrix_rotate_90_cw #(
  parameter int unsigned MAX_SIDE      = 8,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [mr90_pkg::SIDE_W-1:0]     cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [ELEMENT_WIDTH-1:0] in_element,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [ELEMENT_WIDTH-1:0]      out_element,
  output logic                                 out_last
);

  localparam int unsigned STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned SLOT_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned RAM_DEPTH   = 2 * (1 << SLOT_W);

  logic                     wr_en;
  logic [SLOT_W:0]          wr_addr;
  logic [ELEMENT_WIDTH-1:0] wr_data;
  logic                     rd_en;
  logic [SLOT_W:0]          rd_addr;
  logic [ELEMENT_WIDTH-1:0] rd_data;
  logic                     fcmd_valid;
  logic                     fcmd_ready;
  mr90_pkg::cmd_t           fcmd_data;
  logic                     bcmd_valid;
  logic                     bcmd_ready;
  mr90_pkg::cmd_t           bcmd_data;
  logic                     bank_release;

  mr90_front #(
    .MAX_SIDE      (MAX_SIDE),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .SLOT_W        (SLOT_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_element   (in_element),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .cmd_valid    (fcmd_valid),
    .cmd_ready    (fcmd_ready),
    .cmd_data     (fcmd_data),
    .bank_release (bank_release)
  );

  mr90_fifo #(
    .WIDTH ($bits(mr90_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fcmd_valid),
    .push_ready (fcmd_ready),
    .push_data  (fcmd_data),
    .pop_valid  (bcmd_valid),
    .pop_ready  (bcmd_ready),
    .pop_data   (bcmd_data)
  );

  mr90_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mr90_back #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .SLOT_W        (SLOT_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (bcmd_valid),
    .cmd_ready    (bcmd_ready),
    .cmd_data     (bcmd_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .bank_release (bank_release),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_element  (out_element),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire
